@@ hw/rtl/mrpt_pkg.sv @@
// Shared constants and the arctangent table for the point tracker.
// No dependencies; imported by mobile_robot_point_tracker.
package mrpt_pkg;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_MAX_FWD   = 3'd0;
	localparam logic [2:0] REG_MAX_TURN  = 3'd1;
	localparam logic [2:0] REG_ALIGN     = 3'd2;
	localparam logic [2:0] REG_GAIN_FWD  = 3'd3;
	localparam logic [2:0] REG_GAIN_LAT  = 3'd4;
	localparam logic [2:0] REG_GAIN_HEAD = 3'd5;
	localparam logic [2:0] REG_OMNI      = 3'd6;

	// 1/K of the CORDIC in Q30 and in Q28 (Q28 split in two 14-bit halves)
	localparam logic signed [35:0] INVK_Q30     = 36'sd652032874;
	localparam logic signed [16:0] INVK_Q28_HI  = 17'sd9949;
	localparam logic signed [16:0] INVK_Q28_LO  = 17'sd3803;

	// Angle limits, 2^32 = one turn
	localparam logic signed [32:0] ANG_5DEG     = 33'sd59652323;
	localparam logic signed [32:0] ANG_60DEG    = 33'sd715827882;

	// 180/(1000*pi) in Q20
	localparam logic signed [16:0] DEG_PER_KRAD = 17'sd60079;

	// Arrival distances in Q4 mm
	localparam logic signed [35:0] TWO_WHEEL_STOP = 36'sd3200;
	localparam logic [31:0]        OMNI_STOP      = 32'd2400;

	// Reciprocal of 1000 for the lateral term: ceil(2^56/1000) in three
	// 16-bit chunks, lowest first; exact for dividends below 2^46
	localparam logic signed [16:0] RECIP_1000_0 = 17'sd50856;
	localparam logic signed [16:0] RECIP_1000_1 = 17'sd14155;
	localparam logic signed [16:0] RECIP_1000_2 = 17'sd16777;

	// atan(2^-i) with 2^32 = one turn
	function automatic logic [31:0] atan_lut(input logic [4:0] idx);
		logic [31:0] v;
		unique case (idx)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

@@ hw/rtl/mobile_robot_point_tracker.sv @@
// Point-tracking velocity controller: CORDIC, shared multiplier and divider sequence.
// Depends on mrpt_pkg for constants and the arctangent table.
//
// One control tick is one input beat and gives one output beat. The block works on one
// tick at a time: s_tready is high only while the sequencer is idle, and a finished
// result waits in the output register while the next tick is taken. A tick passes the
// idle state, a vectoring pass (skipped for coincident positions), the evaluation state
// and, when the controller runs, a rotation pass; the two-wheel law follows (the divide
// by 1000 of the lateral term is a three-pass reciprocal multiply), or the omni law. A
// result may then wait for m_tready.
// One 48x17 multiplier does every multiply; one add/subtract stage serves CORDIC.
module mobile_robot_point_tracker
	import mrpt_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// target_x, target_y, robot_x, robot_y, robot_heading, desired_speed
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// forward_speed, turn_rate, speed_x, speed_y, arrived, aligning, zero pad
	output logic [63:0]  m_tdata
);

	localparam logic [4:0] S_IDLE = 5'd0,  S_VEC = 5'd1,  S_EVAL = 5'd2,  S_ROT = 5'd3,
		S_R0 = 5'd4,  S_R1 = 5'd5,  S_R2 = 5'd6,  S_EX0 = 5'd7,  S_EX1 = 5'd8,
		S_EY0 = 5'd9, S_EY1 = 5'd10, S_V0 = 5'd11, S_V1 = 5'd12, S_KY = 5'd13,
		S_DLD = 5'd14, S_DIV = 5'd15, S_IN = 5'd16, S_W0 = 5'd17, S_W1 = 5'd18,
		S_TW = 5'd19, S_O0 = 5'd20, S_O1 = 5'd21, S_O2 = 5'd22, S_OUT = 5'd23;

	// Configuration registers
	logic [15:0] max_fwd_q, gain_fwd_q, gain_lat_q, gain_head_q;
	logic [9:0]  max_turn_q, align_turn_q;
	logic        omni_q;

	// Controller state
	logic        align_q, arr_q;

	// Sequencer and datapath
	logic [4:0]         state_q;
	logic [5:0]         cnt_q;
	logic signed [35:0] x_q, y_q, mag_q, ex_q, ey_q;
	logic [31:0]        z_q, r_q;
	logic signed [33:0] e_q;
	logic [15:0]        hd_q, vd_q;
	logic signed [65:0] acc_q;
	logic signed [47:0] v_q, inner_q;
	logic [47:0]        div_q;
	logic               neg_q;
	logic [15:0]        fwd_q;
	logic signed [10:0] turn_q;
	logic signed [16:0] sx_q, sy_q;

	// Input unpack
	logic signed [24:0] dx, dy;
	assign dx = 25'($signed(s_tdata[23:0])) - 25'($signed(s_tdata[71:48]));
	assign dy = 25'($signed(s_tdata[47:24])) - 25'($signed(s_tdata[95:72]));

	// CORDIC step unit
	logic signed [35:0] xs, ys;
	logic [31:0]        atan_w;
	assign xs     = x_q >>> cnt_q[4:0];
	assign ys     = y_q >>> cnt_q[4:0];
	assign atan_w = atan_lut(cnt_q[4:0]);

	// Bearing error against heading, wrapped by 32-bit arithmetic
	logic [31:0]        ediff;
	logic signed [32:0] e_w, ae_w;
	assign ediff = z_q - {hd_q, 16'h0000};
	assign e_w   = 33'($signed(ediff));
	assign ae_w  = (e_w < 0) ? -e_w : e_w;

	// Shared multiplier
	logic signed [47:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [64:0] prod;
	logic signed [65:0] prod_x;
	assign prod   = mul_a * mul_b;
	assign prod_x = 66'(prod);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_R0: begin
				mul_a = 48'(mag_q);
				mul_b = INVK_Q28_LO;
			end
			S_R1: begin
				mul_a = 48'(mag_q);
				mul_b = INVK_Q28_HI;
			end
			S_EX0: begin
				mul_a = $signed({16'h0000, r_q});
				mul_b = $signed({1'b0, x_q[15:0]});
			end
			S_EX1: begin
				mul_a = $signed({16'h0000, r_q});
				mul_b = $signed(x_q[32:16]);
			end
			S_EY0: begin
				mul_a = $signed({16'h0000, r_q});
				mul_b = $signed({1'b0, y_q[15:0]});
			end
			S_EY1: begin
				mul_a = $signed({16'h0000, r_q});
				mul_b = $signed(y_q[32:16]);
			end
			S_V0, S_O0: begin
				mul_a = 48'(x_q);
				mul_b = $signed({1'b0, vd_q});
			end
			S_V1: begin
				mul_a = 48'(ex_q);
				mul_b = $signed({1'b0, gain_fwd_q});
			end
			S_KY: begin
				mul_a = 48'(ey_q);
				mul_b = $signed({1'b0, gain_lat_q});
			end
			S_DLD: begin
				mul_a = 48'(y_q);
				mul_b = $signed({1'b0, gain_head_q});
			end
			S_DIV: begin
				mul_a = $signed(div_q);
				if (cnt_q == 6'd0) mul_b = RECIP_1000_0;
				else if (cnt_q == 6'd1) mul_b = RECIP_1000_1;
				else mul_b = RECIP_1000_2;
			end
			S_W0: begin
				mul_a = inner_q;
				mul_b = $signed({1'b0, vd_q});
			end
			S_W1: begin
				mul_a = $signed(acc_q[55:8]);
				mul_b = DEG_PER_KRAD;
			end
			S_O1: begin
				mul_a = 48'(y_q);
				mul_b = $signed({1'b0, vd_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Distance with rounding, Q4 mm
	logic [65:0] rsum;
	assign rsum = acc_q + 66'h0_8000_0000;

	// Quotient by 1000: top of the reciprocal product, sign restored toward zero
	logic signed [47:0] quot_s;
	assign quot_s = neg_q ? -$signed({10'h000, acc_q[61:24]})
		: $signed({10'h000, acc_q[61:24]});

	// Clamp to +/-lim*2^30 and truncate toward zero
	function automatic logic signed [16:0] sat_q30(input logic signed [65:0] a,
		input logic [15:0] lim);
		logic signed [65:0] l;
		logic signed [65:0] n;
		logic signed [16:0] r;
		l = $signed({20'h0, lim, 30'h0});
		n = -a;
		if (a > l) r = $signed({1'b0, lim});
		else if (a < -l) r = -$signed({1'b0, lim});
		else if (a >= 0) r = $signed(a[46:30]);
		else r = -$signed(n[46:30]);
		return r;
	endfunction

	// Clamp to +/-lim*2^28 and truncate toward zero
	function automatic logic signed [10:0] sat_q28(input logic signed [65:0] a,
		input logic [9:0] lim);
		logic signed [65:0] l;
		logic signed [65:0] n;
		logic signed [10:0] r;
		l = $signed({28'h0, lim, 28'h0});
		n = -a;
		if (a > l) r = $signed({1'b0, lim});
		else if (a < -l) r = -$signed({1'b0, lim});
		else if (a >= 0) r = $signed(a[38:28]);
		else r = -$signed(n[38:28]);
		return r;
	endfunction

	// Forward speed: clamp to max, then to zero or more
	logic [15:0] fwd_w;
	always_comb begin
		if (v_q < 0) fwd_w = '0;
		else if (v_q > $signed({16'h0000, max_fwd_q, 16'h0000})) fwd_w = max_fwd_q;
		else fwd_w = v_q[31:16];
	end

	assign s_tready = (state_q == S_IDLE);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_fwd_q    <= 16'd1000;
			max_turn_q   <= 10'd50;
			align_turn_q <= 10'd22;
			gain_fwd_q   <= 16'd1638;
			gain_lat_q   <= 16'd4096;
			gain_head_q  <= 16'd3277;
			omni_q       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_FWD:   max_fwd_q    <= cfg_data;
				REG_MAX_TURN:  max_turn_q   <= cfg_data[9:0];
				REG_ALIGN:     align_turn_q <= cfg_data[9:0];
				REG_GAIN_FWD:  gain_fwd_q   <= cfg_data;
				REG_GAIN_LAT:  gain_lat_q   <= cfg_data;
				REG_GAIN_HEAD: gain_head_q  <= cfg_data;
				REG_OMNI:      omni_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			align_q  <= 1'b1;
			arr_q    <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			// drop the beat once taken, unless a new one replaces it
			if (m_tvalid && m_tready && state_q != S_OUT) m_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (s_tvalid) state_q <= (dx == 0 && dy == 0) ? S_EVAL : S_VEC;
				end
				S_VEC: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(CORDIC_STEPS - 1)) state_q <= S_EVAL;
				end
				S_EVAL: begin
					cnt_q <= '0;
					priority if (align_q && (e_w > ANG_5DEG || e_w < -ANG_5DEG)) begin
						state_q <= S_OUT;
					end else if (ae_w > ANG_60DEG) begin
						align_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						align_q <= 1'b0;
						state_q <= S_ROT;
					end
				end
				S_ROT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(CORDIC_STEPS - 1)) state_q <= S_R0;
				end
				S_R0: state_q <= S_R1;
				S_R1: state_q <= S_R2;
				S_R2: begin
					if (!omni_q) begin
						state_q <= S_EX0;
					end else if (rsum[63:32] < OMNI_STOP) begin
						arr_q   <= 1'b1;
						state_q <= S_OUT;
					end else begin
						arr_q   <= 1'b0;
						state_q <= S_O0;
					end
				end
				S_EX0: state_q <= S_EX1;
				S_EX1: state_q <= S_EY0;
				S_EY0: begin
					if ($signed(acc_q[65:30]) < TWO_WHEEL_STOP &&
						$signed(acc_q[65:30]) > -TWO_WHEEL_STOP) begin
						arr_q   <= 1'b1;
						state_q <= S_OUT;
					end else begin
						arr_q   <= 1'b0;
						state_q <= S_EY1;
					end
				end
				S_EY1: state_q <= S_V0;
				S_V0:  state_q <= S_V1;
				S_V1:  state_q <= S_KY;
				S_KY:  state_q <= S_DLD;
				S_DLD: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd2) state_q <= S_IN;
				end
				S_IN:  state_q <= S_W0;
				S_W0:  state_q <= S_W1;
				S_W1:  state_q <= S_TW;
				S_TW:  state_q <= S_OUT;
				S_O0:  state_q <= S_O1;
				S_O1:  state_q <= S_O2;
				S_O2:  state_q <= S_OUT;
				S_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				hd_q   <= s_tdata[111:96];
				vd_q   <= s_tdata[127:112];
				fwd_q  <= '0;
				turn_q <= '0;
				sx_q   <= '0;
				sy_q   <= '0;
				// fold the left half-plane by pi
				if (dx < 0) begin
					x_q <= -(36'(dx) <<< 8);
					y_q <= -(36'(dy) <<< 8);
					z_q <= 32'h8000_0000;
				end else begin
					x_q <= 36'(dx) <<< 8;
					y_q <= 36'(dy) <<< 8;
					z_q <= '0;
				end
			end
			S_VEC: begin
				if (y_q >= 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_w;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_w;
				end
			end
			S_EVAL: begin
				mag_q <= x_q;
				x_q   <= INVK_Q30;
				y_q   <= '0;
				e_q   <= 34'(e_w);
				if (align_q && e_w > ANG_5DEG) turn_q <= $signed({1'b0, align_turn_q});
				else if (align_q && e_w < -ANG_5DEG)
					turn_q <= -$signed({1'b0, align_turn_q});
			end
			S_ROT: begin
				if (e_q >= 0) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					e_q <= e_q - $signed({2'b00, atan_w});
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					e_q <= e_q + $signed({2'b00, atan_w});
				end
			end
			S_R0:  acc_q <= prod_x;
			S_R1:  acc_q <= acc_q + (prod_x <<< 14);
			S_R2:  r_q   <= rsum[63:32];
			S_EX0: acc_q <= prod_x;
			S_EX1: acc_q <= acc_q + (prod_x <<< 16);
			S_EY0: begin
				ex_q  <= $signed(acc_q[65:30]);
				acc_q <= prod_x;
			end
			S_EY1: acc_q <= acc_q + (prod_x <<< 16);
			S_V0: begin
				ey_q  <= $signed(acc_q[65:30]);
				acc_q <= prod_x;
			end
			S_V1: acc_q <= (acc_q >>> 14) + prod_x;
			S_KY: begin
				v_q   <= $signed(acc_q[47:0]);
				acc_q <= prod_x;
			end
			S_DLD: begin
				neg_q <= (acc_q < 0);
				div_q <= (acc_q < 0) ? 48'(-acc_q) : acc_q[47:0];
				acc_q <= prod_x;
			end
			S_DIV: begin
				// park the heading term, then fold in one reciprocal chunk per cycle
				if (cnt_q == 6'd0) begin
					inner_q <= 48'(acc_q >>> 26);
					acc_q   <= prod_x;
				end else begin
					acc_q <= (acc_q >>> 16) + prod_x;
				end
			end
			S_IN:  inner_q <= inner_q + quot_s;
			S_W0:  acc_q   <= prod_x;
			S_W1:  acc_q   <= prod_x;
			S_TW: begin
				fwd_q  <= fwd_w;
				turn_q <= sat_q28(acc_q, max_turn_q);
			end
			S_O0: acc_q <= prod_x;
			S_O1: begin
				sx_q  <= sat_q30(acc_q, max_fwd_q);
				acc_q <= prod_x;
			end
			S_O2: sy_q <= sat_q30(acc_q, max_fwd_q);
			S_OUT: begin
				if (!m_tvalid || m_tready)
					m_tdata <= {1'b0, align_q, arr_q, sy_q, sx_q, turn_q, fwd_q};
			end
			default: ;
		endcase
	end

	// Arrival always stops every speed unless the beat is an alignment turn
	a_arrive_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[61] && !m_tdata[62] |-> m_tdata[60:0] == '0)
		else $error("arrival beat carries a nonzero speed");

	// Two-wheel beats never carry omni speeds
	a_tw_no_omni: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !omni_q |-> m_tdata[60:27] == '0)
		else $error("two-wheel beat carries omni speeds");

	// Omni beats outside alignment carry no two-wheel commands
	a_omni_no_tw: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && omni_q && !m_tdata[62] |-> m_tdata[26:0] == '0)
		else $error("omni beat carries two-wheel commands");

	// CORDIC iterations stay inside the configured step count
	a_cordic_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_VEC || state_q == S_ROT) |-> cnt_q < 6'(CORDIC_STEPS))
		else $error("CORDIC step counter overran");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for mobile_robot_point_tracker: directed rows, then random ticks
// checked against a bit-exact predictor of the tracking law. Depends on mrpt_pkg and the tracker.
module testbench;
	import mrpt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     STEPS      = 16;
	localparam int     DRAIN      = 200;
	localparam longint CYCLE_CAP  = 3000000;
	localparam longint Q28        = 64'sd268435456;
	localparam longint Q30        = 64'sd1073741824;
	localparam longint COS_START  = 64'sd652032874;
	localparam longint INV_GAIN   = 64'sd163008219;
	localparam longint LIM_5DEG   = 64'sd59652323;
	localparam longint LIM_60DEG  = 64'sd715827882;
	localparam longint DEG_SCALE  = 64'sd60079;
	localparam longint DIFF_STOP  = 64'sd3200;
	localparam longint OMNI_RANGE = 64'sd2400;

	typedef struct packed {
		logic signed [23:0] tx, ty, rx, ry;
		logic signed [15:0] hd;
		logic [15:0]        vd;
	} tick_t;

	typedef struct packed {
		logic [15:0]        fwd;
		logic signed [10:0] turn;
		logic signed [16:0] sx, sy;
		logic               arr, aln;
	} cmd_t;

	typedef struct {
		tick_t t;
		bit    typed;
		cmd_t  c;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [15:0]  cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;

	mobile_robot_point_tracker dut (.*);

	// angle of atan(2^-i), full turn = 2^32
	logic [31:0] arctan [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// controller state and register copy
	logic        align_req = 1'b1;
	logic        at_goal   = 1'b0;
	logic [15:0] max_fwd = 16'd1000, k_fwd = 16'd1638, k_lat = 16'd4096, k_head = 16'd3277;
	logic [9:0]  max_turn = 10'd50, align_rate = 10'd22;
	logic        omni = 1'b0;

	cmd_t   expected_cmds [$];
	row_t   plan [$];
	int     errors = 0;
	int     gap_pct = 0;
	int     stall_pct = 0;
	longint cycles = 0;

	function automatic longint clamp2(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// vectoring pass: bearing of (dx, dy) and the gain-scaled magnitude
	function automatic logic [31:0] bearing_of(longint dx, longint dy, output longint mag);
		longint x, y, xs, ys;
		logic [31:0] z;
		x = dx * 256;
		y = dy * 256;
		z = '0;
		mag = 0;
		if (dx == 0 && dy == 0) return z;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h80000000;
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += arctan[i];
			end else begin
				x -= ys; y += xs; z -= arctan[i];
			end
		end
		mag = x;
		return z;
	endfunction

	// one control tick: advance the state and return the command beat
	function automatic cmd_t track(tick_t t);
		longint dx, dy, vd, mag, e, ae, c, s, x, y, xs, ys, ang, r;
		longint ex, ey, v, inner, w, lim;
		logic [31:0] ediff;
		cmd_t o;
		o = '0;
		dx = longint'(t.tx) - longint'(t.rx);
		dy = longint'(t.ty) - longint'(t.ry);
		vd = longint'(t.vd);
		ediff = bearing_of(dx, dy, mag) - {t.hd, 16'h0000};
		e = longint'($signed(ediff));
		ae = e < 0 ? -e : e;
		if (align_req && e > LIM_5DEG) begin
			o.turn = $signed({1'b0, align_rate});
		end else if (align_req && e < -LIM_5DEG) begin
			o.turn = 11'(-longint'(align_rate));
		end else if (ae > LIM_60DEG) begin
			align_req = 1'b1;
		end else begin
			align_req = 1'b0;
			// rotate the unit vector by the error to get cos and sin
			x = COS_START;
			y = 0;
			ang = e;
			for (int i = 0; i < STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (ang >= 0) begin
					x -= ys; y += xs; ang -= longint'(arctan[i]);
				end else begin
					x += ys; y -= xs; ang += longint'(arctan[i]);
				end
			end
			c = x;
			s = y;
			r = longint'((longint'(mag) * INV_GAIN + 64'sh80000000) >> 32);
			if (!omni) begin
				ex = (r * c) >>> 30;
				ey = (r * s) >>> 30;
				v = ((vd * c) >>> 14) + longint'(k_fwd) * ex;
				inner = (longint'(k_lat) * ey) / 1000 + ((longint'(k_head) * s) >>> 26);
				w = ((vd * inner) >>> 8) * DEG_SCALE;
				if (v > (longint'(max_fwd) <<< 16)) v = longint'(max_fwd) <<< 16;
				w = clamp2(w, longint'(max_turn) <<< 28);
				if ((ex < 0 ? -ex : ex) < DIFF_STOP) begin
					at_goal = 1'b1;
				end else begin
					if (v < 0) v = 0;
					o.fwd = 16'(v >>> 16);
					o.turn = 11'(w / Q28);
					at_goal = 1'b0;
				end
			end else begin
				lim = longint'(max_fwd) <<< 30;
				if (r < OMNI_RANGE) begin
					at_goal = 1'b1;
				end else begin
					o.sx = 17'(clamp2(vd * c, lim) / Q30);
					o.sy = 17'(clamp2(vd * s, lim) / Q30);
					at_goal = 1'b0;
				end
			end
		end
		o.arr = at_goal;
		o.aln = align_req;
		return o;
	endfunction

	task automatic add_row(input longint tx, ty, rx, ry, hd, vd, input bit typed,
			input cmd_t c);
		row_t rw;
		rw.t = {tx[23:0], ty[23:0], rx[23:0], ry[23:0], hd[15:0], vd[15:0]};
		rw.typed = typed;
		rw.c = c;
		plan.push_back(rw);
	endtask

	// write all seven registers, one per beat, while the block is idle
	task automatic load_cfg(input logic [15:0] vals [7]);
		logic [2:0] idx [7];
		idx = '{REG_MAX_FWD, REG_MAX_TURN, REG_ALIGN, REG_GAIN_FWD, REG_GAIN_LAT,
			REG_GAIN_HEAD, REG_OMNI};
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			case (idx[i])
				REG_MAX_FWD:   max_fwd = vals[i];
				REG_MAX_TURN:  max_turn = vals[i][9:0];
				REG_ALIGN:     align_rate = vals[i][9:0];
				REG_GAIN_FWD:  k_fwd = vals[i];
				REG_GAIN_LAT:  k_lat = vals[i];
				REG_GAIN_HEAD: k_head = vals[i];
				REG_OMNI:      omni = vals[i][0];
				default: ;
			endcase
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// present one tick, hold it until taken, then queue its command
	task automatic send(input tick_t t, input bit typed, input cmd_t c);
		cmd_t res;
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= {t.vd, t.hd, t.ry, t.rx, t.ty, t.tx};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		res = track(t);
		expected_cmds.push_back(typed ? c : res);
	endtask

	// mostly ticks aimed near the current bearing, some raw noise
	task automatic random_tick(output tick_t t);
		longint rx, ry, dx, dy, mag, off, span;
		logic [31:0] b;
		int k;
		k = $urandom_range(9);
		if (k < 2) begin
			t = {$urandom, $urandom, $urandom, $urandom};
			return;
		end
		span = (k < 4) ? 400 : (k < 8) ? 20000 : 3000000;
		rx = longint'($urandom_range(8000000)) - 4000000;
		ry = longint'($urandom_range(8000000)) - 4000000;
		dx = longint'($urandom_range(32'(span * 2))) - span;
		dy = longint'($urandom_range(32'(span * 2))) - span;
		b = bearing_of(dx, dy, mag);
		case ($urandom_range(3))
			0: off = longint'($urandom_range(2400)) - 1200;
			1: off = longint'($urandom_range(1800)) + 10000;
			2: off = -(longint'($urandom_range(1800)) + 10000);
			default: off = longint'($urandom_range(65535));
		endcase
		t.tx = 24'(rx + dx);
		t.ty = 24'(ry + dy);
		t.rx = 24'(rx);
		t.ry = 24'(ry);
		t.hd = b[31:16] + off[15:0];
		t.vd = ($urandom_range(1)) ? 16'($urandom_range(65535)) : 16'($urandom_range(3000));
	endtask

	task automatic drain;
		while (expected_cmds.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// result side: random stall, compare each beat with the oldest expectation
	always @(posedge clk) begin
		cmd_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[15:0], m_tdata[26:16], m_tdata[43:27], m_tdata[60:44],
				m_tdata[61], m_tdata[62]};
			if (expected_cmds.size() == 0) begin
				$display("%0t: unexpected beat %h", $time, m_tdata);
				errors++;
			end else begin
				want = expected_cmds.pop_front();
				if (got.fwd !== want.fwd)
					$display("%0t: forward_speed exp %0d got %0d", $time, want.fwd, got.fwd);
				if (got.turn !== want.turn)
					$display("%0t: turn_rate exp %0d got %0d", $time, want.turn, got.turn);
				if (got.sx !== want.sx)
					$display("%0t: speed_x exp %0d got %0d", $time, want.sx, got.sx);
				if (got.sy !== want.sy)
					$display("%0t: speed_y exp %0d got %0d", $time, want.sy, got.sy);
				if (got.arr !== want.arr)
					$display("%0t: arrived exp %0d got %0d", $time, want.arr, got.arr);
				if (got.aln !== want.aln)
					$display("%0t: aligning exp %0d got %0d", $time, want.aln, got.aln);
				if (got !== want) errors++;
			end
		end
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		logic [15:0] vals [7];
		cmd_t z;
		tick_t t;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset settings; typed rows are fixed by the law
		z = '0;
		add_row(1000, 0, 0, 0, 16384, 500, 1, '{16'd0, -11'sd22, 17'sd0, 17'sd0, 1'b0, 1'b1});
		add_row(1000, 0, 0, 0, 0, 500, 0, z);
		// coincident positions: zero bearing, zero distance, arrived
		add_row(77, -5, 77, -5, 0, 900, 1, '{16'd0, 11'sd0, 17'sd0, 17'sd0, 1'b1, 1'b0});
		// target behind: re-arm, held arrival repeats
		add_row(-1000, 0, 0, 0, 0, 500, 1, '{16'd0, 11'sd0, 17'sd0, 17'sd0, 1'b1, 1'b1});
		add_row(-1000, 0, 0, 0, 0, 500, 0, z);
		// bearing close to the five and sixty degree limits
		add_row(5000, 0, 0, 0, 910, 1200, 0, z);
		add_row(5000, 0, 0, 0, -911, 1200, 0, z);
		add_row(5000, 0, 0, 0, 0, 1200, 0, z);
		add_row(5000, 0, 0, 0, 10922, 1200, 0, z);
		add_row(5000, 0, 0, 0, -10923, 1200, 0, z);
		add_row(5000, 0, 0, 0, 10924, 1200, 0, z);
		// field extremes
		add_row(8388607, 8388607, -8388608, -8388608, -32768, 65535, 0, z);
		add_row(-8388608, -8388608, 8388607, 8388607, 32767, 0, 0, z);
		add_row(8388607, 0, -8388608, 0, 0, 65535, 0, z);
		add_row(100, 100, 0, 0, 8192, 65535, 0, z);
		add_row(1000, 0, 0, 0, 0, 65535, 0, z);
		foreach (plan[i]) send(plan[i].t, plan[i].typed, plan[i].c);
		s_tvalid <= 1'b0;
		drain();

		// random phases over several register settings and idle patterns
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: vals = '{16'hFFFF, 16'h3FF, 16'h3FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0};
				1: vals = '{16'hFFFF, 16'h3FF, 16'h3FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1};
				2: vals = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
				3: vals = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1};
				4: vals = '{16'd1000, 16'd50, 16'd22, 16'd1638, 16'd4096, 16'd3277, 16'd1};
				default: vals = '{16'($urandom_range(65535)), 16'($urandom_range(1023)),
					16'($urandom_range(1023)), 16'($urandom_range(65535)),
					16'($urandom_range(65535)), 16'($urandom_range(65535)),
					16'($urandom_range(1))};
			endcase
			load_cfg(vals);
			case (p % 4)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 75; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 75; end
				default: begin gap_pct = 32; stall_pct = 32; end
			endcase
			for (int n = 0; n < 62; n++) begin
				random_tick(t);
				send(t, 0, z);
			end
			s_tvalid <= 1'b0;
			drain();
		end

		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
